@@ hdl/nmeagga_pkg.sv @@
// Shared types for the GGA sentence field extractor.
// Field codes and the per-byte result record; no dependencies.
package nmeagga_pkg;

    typedef enum logic [3:0] {
        F_NONE = 4'd0,
        F_TIME = 4'd1,
        F_LAT  = 4'd2,
        F_LATH = 4'd3,
        F_LON  = 4'd4,
        F_LONH = 4'd5,
        F_FIX  = 4'd6,
        F_ALT  = 4'd7,
        F_ALTU = 4'd8
    } t_field;

    typedef struct packed {
        t_field             field_code;
        logic [7:0]         char_out;
        logic [3:0]         char_index;
        logic               field_closed;
        logic               sentence_done;
        logic               sync_lost;
        logic               fix_ok;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [31:0] altitude;
        logic [7:0]         lat_hemisphere;
        logic [7:0]         lon_hemisphere;
    } t_result;

endpackage

@@ hdl/nmeagga_core.sv @@
// Parser state and per-byte decode for the GGA sentence field extractor.
// Depends on nmeagga_pkg for t_field and t_result.
module nmeagga_core #(
    parameter int FIELD_LEN = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic [7:0]            i_byte,
    output nmeagga_pkg::t_result  o_res
);
    import nmeagga_pkg::*;

    localparam int CW = (FIELD_LEN > 2) ? $clog2(FIELD_LEN) : 1;
    localparam int TMPL_LEN = 28;
    localparam logic [4:0] HDR_END = 5'd6;
    localparam logic [8*TMPL_LEN-1:0] TMPL = "$GPGGA,t,l,L,o,O,s,i,i,a,A,E";
    localparam logic [30:0] VAL_MAX = '1;
    localparam logic [CW-1:0] CNT_LIM = CW'(FIELD_LEN - 1);

    function automatic logic [7:0] tmpl_char(input logic [5:0] pos);
        logic [7:0] c;
        c = 8'd0;
        if (int'(pos) < TMPL_LEN) begin
            c = TMPL[8*(TMPL_LEN-1-int'(pos)) +: 8];
        end
        return c;
    endfunction

    function automatic t_field letter_code(input logic [7:0] l);
        t_field f;
        case (l)
            "t":     f = F_TIME;
            "l":     f = F_LAT;
            "L":     f = F_LATH;
            "o":     f = F_LON;
            "O":     f = F_LONH;
            "s":     f = F_FIX;
            "a":     f = F_ALT;
            "A":     f = F_ALTU;
            default: f = F_NONE;
        endcase
        return f;
    endfunction

    logic [4:0]    r_pos,   n_pos;
    logic [CW-1:0] r_cnt,   n_cnt;
    t_field        r_field, n_field;
    logic [30:0]   r_acc,   n_acc;
    logic [7:0]    r_fix,   n_fix;
    logic [30:0]   r_lat,   n_lat;
    logic [30:0]   r_lon,   n_lon;
    logic [30:0]   r_alt,   n_alt;
    logic [7:0]    r_lath,  n_lath;
    logic [7:0]    r_lonh,  n_lonh;

    logic [5:0]  nxt;
    logic [5:0]  jump;
    logic [3:0]  digit;
    logic [34:0] prod;
    logic        is_digit;
    logic        ok;
    t_result     res;

    assign nxt      = {1'b0, r_pos} + 6'd1;
    assign jump     = nxt + 6'd1;
    assign is_digit = (i_byte >= "0") && (i_byte <= "9");
    assign digit    = 4'(i_byte - "0");
    assign prod     = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {31'd0, digit};

    always_comb begin
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_field = r_field;
        n_acc   = r_acc;
        n_fix   = r_fix;
        n_lat   = r_lat;
        n_lon   = r_lon;
        n_alt   = r_alt;
        n_lath  = r_lath;
        n_lonh  = r_lonh;
        res     = '0;

        if (r_pos <= HDR_END) begin
            if (i_byte != tmpl_char({1'b0, r_pos})) begin
                res.sync_lost = (r_pos != 5'd0);
                n_pos   = 5'd0;
                n_cnt   = '0;
                n_field = F_NONE;
                n_acc   = '0;
            end else if (r_pos < HDR_END) begin
                n_pos = r_pos + 5'd1;
            end else begin
                n_pos   = HDR_END + 5'd1;
                n_cnt   = '0;
                n_acc   = '0;
                n_field = F_TIME;
            end
        end else if (i_byte == ",") begin
            if ((int'(jump) < TMPL_LEN) && (tmpl_char(nxt) == ",")) begin
                res.field_closed = (r_field != F_NONE);
                case (r_field)
                    F_LAT:   n_lat = r_acc;
                    F_LON:   n_lon = r_acc;
                    F_ALT:   n_alt = r_acc;
                    default: ;
                endcase
                n_cnt = '0;
                n_acc = '0;
                if (tmpl_char(jump) == "E") begin
                    res.sentence_done = 1'b1;
                    n_pos   = 5'd0;
                    n_field = F_NONE;
                end else begin
                    n_pos   = jump[4:0];
                    n_field = letter_code(tmpl_char(jump));
                end
            end else begin
                res.sync_lost = 1'b1;
                n_pos   = 5'd0;
                n_cnt   = '0;
                n_field = F_NONE;
                n_acc   = '0;
            end
        end else if ((r_field != F_NONE) && (r_cnt < CNT_LIM)) begin
            res.field_code = r_field;
            res.char_out   = i_byte;
            res.char_index = 4'(r_cnt);
            if (r_field inside {F_LAT, F_LON, F_ALT}) begin
                if (is_digit) begin
                    n_acc = (prod > {4'd0, VAL_MAX}) ? VAL_MAX : prod[30:0];
                end
            end else if (r_cnt == '0) begin
                case (r_field)
                    F_LATH:  n_lath = i_byte;
                    F_LONH:  n_lonh = i_byte;
                    F_FIX:   n_fix  = i_byte;
                    default: ;
                endcase
            end
            n_cnt = r_cnt + CW'(1);
        end

        ok = (n_fix >= "1") && (n_fix <= "5");
        res.fix_ok         = ok;
        res.latitude       = ok ? {1'b0, n_lat} : '1;
        res.longitude      = ok ? {1'b0, n_lon} : '1;
        res.altitude       = ok ? {1'b0, n_alt} : '1;
        res.lat_hemisphere = n_lath;
        res.lon_hemisphere = n_lonh;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 5'd0;
            r_cnt   <= '0;
            r_field <= F_NONE;
            r_acc   <= '0;
            r_fix   <= 8'd0;
            r_lat   <= '0;
            r_lon   <= '0;
            r_alt   <= '0;
            r_lath  <= 8'd0;
            r_lonh  <= 8'd0;
        end else if (i_adv) begin
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_field <= n_field;
            r_acc   <= n_acc;
            r_fix   <= n_fix;
            r_lat   <= n_lat;
            r_lon   <= n_lon;
            r_alt   <= n_alt;
            r_lath  <= n_lath;
            r_lonh  <= n_lonh;
        end
    end

    a_done_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && res.sentence_done) |=> (r_pos == 5'd0 && r_field == F_NONE))
        else $error("parser not rearmed after sentence end");

    a_lost_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && res.sync_lost) |=> (r_pos == 5'd0))
        else $error("parser not back at start after sync loss");

    a_pos_on_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos > HDR_END) |-> (r_pos[0] && r_pos <= 5'd25))
        else $error("template position off a field letter");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LIM)
        else $error("field byte count past limit");

    a_event_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.field_code != F_NONE) |-> !(res.field_closed || res.sync_lost
                                         || res.sentence_done))
        else $error("tagged byte also flagged as separator event");

endmodule

@@ hdl/nmea_gga_field_extractor.sv @@
// Top level of the GGA sentence field extractor: stream ports and result register.
// Depends on nmeagga_pkg and nmeagga_core.
//
// Takes one ASCII byte per request and returns one result per byte, tagged with
// the GGA field it belongs to, along with the committed latitude, longitude and
// altitude digit strings as saturating integers (-1 without a valid fix) and the
// stored hemisphere characters. Throughput is one byte per clock while the output
// register is empty or the consumer is ready; each result is registered as its byte
// is taken and shows on the output from the next cycle, held in a single register.
// The per-byte cost is one template compare and one multiply-by-ten accumulate.
// tlast marks the comma that completes the sentence.
module nmea_gga_field_extractor #(
    parameter int FIELD_LEN = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] byte_in
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [7:0] char_out, [11:8] char_index, [12] field_closed, [13] sync_lost,
    // [14] fix_ok, [46:15] latitude, [78:47] longitude, [110:79] altitude,
    // [118:111] lat_hemisphere, [126:119] lon_hemisphere, [127] zero
    output logic [127:0] o_m_axis_tdata,
    output logic [3:0]   o_m_axis_tuser,   // [3:0] field_code
    output logic         o_m_axis_tlast    // sentence_done
);
    import nmeagga_pkg::*;

    logic    accept;
    t_result core_res;
    logic    r_valid;
    t_result r_res;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    nmeagga_core #(
        .FIELD_LEN(FIELD_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (accept),
        .i_byte  (i_s_axis_tdata),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tuser  = r_res.field_code;
    assign o_m_axis_tlast  = r_res.sentence_done;
    assign o_m_axis_tdata  = {1'b0,
                              r_res.lon_hemisphere,
                              r_res.lat_hemisphere,
                              r_res.altitude,
                              r_res.longitude,
                              r_res.latitude,
                              r_res.fix_ok,
                              r_res.sync_lost,
                              r_res.field_closed,
                              r_res.char_index,
                              r_res.char_out};

endmodule
